FILE: hdl/http_byte_range_parser_defines.svh
// Assertion macros of the byte range parser, used by its result queue.
`ifndef HTTP_BYTE_RANGE_PARSER_DEFINES_SVH
`define HTTP_BYTE_RANGE_PARSER_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define HBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must hold in the cycle after the trigger.
`define HBR_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

FILE: hdl/hbr_pkg.sv
// Shared types, constants and helper functions of the byte range parser.
`timescale 1ns / 1ps
package hbr_pkg;

  localparam int OFFSET_WIDTH = 48;
  localparam int OUT_DEPTH    = 4;

  localparam logic [2:0] PREFIX_LEN = 3'd6;

  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_DASH  = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    KIND_RANGE     = 2'd0,
    KIND_OK        = 2'd1,
    KIND_UNSAT     = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_FIRST  = 3'b010,
    PH_SECOND = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] chr;
    logic       final_char;
  } hbr_in_t;

  typedef struct packed {
    kind_e                   kind;
    logic [OFFSET_WIDTH-1:0] range_first;
    logic [OFFSET_WIDTH-1:0] range_end;
    logic                    last_of_run;
  } hbr_out_t;

  // Work handed from the character parser to the range stage.
  typedef struct packed {
    logic                    close;
    logic                    last;
    logic                    failed;
    logic                    malformed;
    logic                    has_first;
    logic                    has_second;
    logic [OFFSET_WIDTH-1:0] first_value;
    logic [OFFSET_WIDTH-1:0] second_value;
  } hbr_req_t;

  // Up to two result words are written into the output queue per cycle.
  typedef struct packed {
    logic [1:0] cnt;
    hbr_out_t   word0;
    hbr_out_t   word1;
  } hbr_wr_t;

  function automatic logic [7:0] prefix_char(logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h62;
      3'd1:    c = 8'h79;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h73;
      3'd5:    c = 8'h3D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/hbr_parser.sv
// Input register and per-character parsing state of the byte range parser.
`timescale 1ns / 1ps
module hbr_parser import hbr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  hbr_in_t  in_word_i,
  input  logic     req_take_i,
  output logic     req_valid_o,
  output hbr_req_t req_o
);

  localparam int AccW = OFFSET_WIDTH + 4;

  typedef struct packed {
    logic fail;
    logic malf;
  } judge_t;

  // Verdict on a part as it closes: no dash is unsatisfiable, a bad number or
  // no number on either side is malformed.
  function automatic judge_t judge(phase_e ph, logic bad, logic hf, logic hs);
    judge_t j;
    j = '0;
    if (ph != PH_SECOND) begin
      j.fail = 1'b1;
    end else if (bad || (!hf && !hs)) begin
      j.fail = 1'b1;
      j.malf = 1'b1;
    end
    return j;
  endfunction

  logic                    in_valid_q, in_valid_d;
  hbr_in_t                 in_word_q;
  logic                    req_valid_q, req_valid_d;
  hbr_req_t                req_q, req_d;
  logic [2:0]              pp_q, pp_d;
  phase_e                  ph_q, ph_d;
  logic [OFFSET_WIDTH-1:0] fv_q, fv_d, sv_q, sv_d;
  logic                    hf_q, hf_d, hs_q, hs_d;
  logic                    bad_q, bad_d;
  logic                    failed_q, failed_d;
  logic                    malf_q, malf_d;

  logic                    pipe_free, step, in_ready;
  logic                    is_digit, take;
  logic [OFFSET_WIDTH-1:0] acc_in;
  logic [AccW-1:0]         acc_sum;
  logic                    acc_ovf;
  judge_t                  jv;

  assign pipe_free  = !req_valid_q || req_take_i;
  assign step       = in_valid_q && pipe_free;
  assign in_ready   = !in_valid_q || step;
  assign in_stall_o = !in_ready;
  assign in_valid_d = in_ready ? in_valid_i : in_valid_q;
  assign is_digit   = (in_word_q.chr >= CHR_ZERO) && (in_word_q.chr <= CHR_NINE);

  always_comb begin
    pp_d     = pp_q;
    ph_d     = ph_q;
    fv_d     = fv_q;
    sv_d     = sv_q;
    hf_d     = hf_q;
    hs_d     = hs_q;
    bad_d    = bad_q;
    failed_d = failed_q;
    malf_d   = malf_q;
    take     = 1'b0;
    acc_in   = '0;
    acc_sum  = '0;
    acc_ovf  = 1'b0;
    jv       = '0;
    req_d    = '0;

    if (step && !failed_q) begin
      if (pp_q < PREFIX_LEN) begin
        if (in_word_q.chr == prefix_char(pp_q)) begin
          pp_d = pp_q + 3'd1;
        end else begin
          failed_d = 1'b1;
          malf_d   = 1'b0;
        end
      end else if (in_word_q.chr == CHR_COMMA) begin
        jv = judge(ph_q, bad_q, hf_q, hs_q);
        if (jv.fail) begin
          failed_d = 1'b1;
          malf_d   = jv.malf;
        end else begin
          req_d.close        = 1'b1;
          req_d.has_first    = hf_q;
          req_d.has_second   = hs_q;
          req_d.first_value  = fv_q;
          req_d.second_value = sv_q;
          ph_d  = PH_SKIP;
          fv_d  = '0;
          sv_d  = '0;
          hf_d  = 1'b0;
          hs_d  = 1'b0;
          bad_d = 1'b0;
        end
      end else begin
        take = 1'b1;
        unique case (ph_q)
          PH_SKIP: begin
            if (in_word_q.chr == CHR_SPACE) begin
              take = 1'b0;
            end else if (in_word_q.chr == CHR_DASH) begin
              ph_d = PH_SECOND;
              take = 1'b0;
            end else begin
              ph_d = PH_FIRST;
            end
          end
          PH_FIRST: begin
            if (in_word_q.chr == CHR_DASH) begin
              ph_d = PH_SECOND;
              take = 1'b0;
            end
          end
          PH_SECOND: begin
          end
          default: begin
          end
        endcase
        // Decimal accumulate: ten times the value is two shifted copies added.
        acc_in  = (ph_d == PH_FIRST) ? fv_q : sv_q;
        acc_sum = AccW'({acc_in, 3'b000}) + AccW'({acc_in, 1'b0})
                + AccW'(in_word_q.chr[3:0]);
        acc_ovf = |acc_sum[AccW-1:OFFSET_WIDTH];
        if (take) begin
          if (ph_d == PH_FIRST) begin
            hf_d = 1'b1;
          end else begin
            hs_d = 1'b1;
          end
          if (!bad_q) begin
            if (!is_digit || acc_ovf) begin
              bad_d = 1'b1;
            end else if (ph_d == PH_FIRST) begin
              fv_d = acc_sum[OFFSET_WIDTH-1:0];
            end else begin
              sv_d = acc_sum[OFFSET_WIDTH-1:0];
            end
          end
        end
      end
    end

    if (step && in_word_q.final_char) begin
      if (!failed_d) begin
        if ((pp_d < PREFIX_LEN) || (ph_d == PH_SKIP)) begin
          failed_d = 1'b1;
          malf_d   = 1'b0;
        end else begin
          jv = judge(ph_d, bad_d, hf_d, hs_d);
          if (jv.fail) begin
            failed_d = 1'b1;
            malf_d   = jv.malf;
          end else begin
            req_d.close        = 1'b1;
            req_d.has_first    = hf_d;
            req_d.has_second   = hs_d;
            req_d.first_value  = fv_d;
            req_d.second_value = sv_d;
          end
        end
      end
      req_d.last      = 1'b1;
      req_d.failed    = failed_d;
      req_d.malformed = malf_d;
      // The header is finished: back to the reset state for the next one.
      pp_d     = '0;
      ph_d     = PH_SKIP;
      fv_d     = '0;
      sv_d     = '0;
      hf_d     = 1'b0;
      hs_d     = 1'b0;
      bad_d    = 1'b0;
      failed_d = 1'b0;
      malf_d   = 1'b0;
    end
  end

  assign req_valid_d = pipe_free ? (step && (req_d.close || req_d.last)) : req_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      req_valid_q <= 1'b0;
      pp_q        <= '0;
      ph_q        <= PH_SKIP;
      fv_q        <= '0;
      sv_q        <= '0;
      hf_q        <= 1'b0;
      hs_q        <= 1'b0;
      bad_q       <= 1'b0;
      failed_q    <= 1'b0;
      malf_q      <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      req_valid_q <= req_valid_d;
      pp_q        <= pp_d;
      ph_q        <= ph_d;
      fv_q        <= fv_d;
      sv_q        <= sv_d;
      hf_q        <= hf_d;
      hs_q        <= hs_d;
      bad_q       <= bad_d;
      failed_q    <= failed_d;
      malf_q      <= malf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready) begin
      in_word_q <= in_word_i;
    end
    if (pipe_free) begin
      req_q <= req_d;
    end
  end

  assign req_valid_o = req_valid_q;
  assign req_o       = req_q;

endmodule

FILE: hdl/hbr_range.sv
// Clamps a closed part to the file size and forms range and status words.
`timescale 1ns / 1ps
module hbr_range import hbr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  input  hbr_req_t                req_i,
  input  logic [OFFSET_WIDTH-1:0] file_size_i,
  input  logic                    room_i,
  output logic                    req_take_o,
  output hbr_wr_t                 wr_o
);

  logic                    emitted_q, emitted_d;
  logic [OFFSET_WIDTH-1:0] lo, hi;
  logic                    emit;
  hbr_out_t                range_word, status_word;
  kind_e                   status;

  assign req_take_o = req_valid_i && room_i;

  always_comb begin
    if (!req_i.has_first) begin
      // Suffix form: the last N bytes, from zero when N exceeds the file.
      lo = (req_i.second_value > file_size_i) ? '0 : file_size_i - req_i.second_value;
      hi = file_size_i;
    end else begin
      lo = req_i.first_value;
      if (!req_i.has_second || (req_i.second_value >= file_size_i)) begin
        hi = file_size_i;
      end else begin
        hi = req_i.second_value + OFFSET_WIDTH'(1);
      end
    end
  end

  assign emit = req_i.close && (lo < hi);

  always_comb begin
    if (req_i.failed) begin
      status = req_i.malformed ? KIND_MALFORMED : KIND_UNSAT;
    end else begin
      status = (emitted_q || emit) ? KIND_OK : KIND_UNSAT;
    end
  end

  assign range_word  = '{kind: KIND_RANGE, range_first: lo, range_end: hi, last_of_run: 1'b0};
  assign status_word = '{kind: status, range_first: '0, range_end: '0, last_of_run: 1'b1};

  always_comb begin
    wr_o.cnt   = req_take_o ? (2'(emit) + 2'(req_i.last)) : 2'd0;
    wr_o.word0 = emit ? range_word : status_word;
    wr_o.word1 = status_word;
  end

  always_comb begin
    emitted_d = emitted_q;
    if (req_take_o) begin
      emitted_d = req_i.last ? 1'b0 : (emitted_q || emit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emitted_q <= 1'b0;
    end else begin
      emitted_q <= emitted_d;
    end
  end

endmodule

FILE: hdl/hbr_out_fifo.sv
// Small queue: takes up to two words a cycle, hands out one unless stalled.
`timescale 1ns / 1ps
`include "http_byte_range_parser_defines.svh"
module hbr_out_fifo import hbr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  hbr_wr_t  wr_i,
  output logic     room_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output hbr_out_t out_word_o
);

  localparam int PtrW = $clog2(OUT_DEPTH);
  localparam int CntW = $clog2(OUT_DEPTH + 1);

  hbr_out_t            mem_q [OUT_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [PtrW-1:0]     wr_ptr_nx;
  logic                pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_word_o  = mem_q[rd_ptr_q];
  // Room for two words, judged on the registered count alone.
  assign room_o      = (count_q <= CntW'(OUT_DEPTH - 2));
  assign wr_ptr_nx   = wr_ptr_q + PtrW'(1);

  assign wr_ptr_d = wr_ptr_q + PtrW'(wr_i.cnt);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign count_d  = count_q + CntW'(wr_i.cnt) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_i.word0;
    end
    if (wr_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nx] <= wr_i.word1;
    end
  end

  `HBR_ASSERT(a_count_bound, count_q <= CntW'(OUT_DEPTH), "result queue count out of range")
  `HBR_ASSERT(a_no_overflow, (int'(count_q) + int'(wr_i.cnt)) <= OUT_DEPTH,
              "result queue written beyond its depth")
  `HBR_ASSERT_NEXT(a_pop_only, pop && (wr_i.cnt == 2'd0),
                   count_q == $past(count_q) - CntW'(1), "result queue count slipped on a read")

endmodule

FILE: hdl/http_byte_range_parser.sv
// Top level of the HTTP byte range header parser.
`timescale 1ns / 1ps
// Usage:
// Header characters arrive one word per cycle on the input channel while it is
// not stalled; final_char marks the last character of a header. Each part that
// closes with a non-empty range produces a word of kind range; the last character
// always produces a status word with last_of_run set. On a failure status the
// consumer discards the ranges already delivered for that header.
// The file size register is written on the configuration channel, which is always
// ready. The user must write it only while no header is being processed; the block
// itself does not enforce this. Each character passes the input register and then
// the parse stage's request register before the range stage writes the queue.
// Throughput: one character per cycle when nothing stalls, set by the single parse
// stage. A character yields at most two words; a four-word result queue absorbs them.
// When the receiver stalls, the queue fills; with fewer than two free entries the
// range stage holds its word, and the input stalls once the input register is full.
// Reset clears all parsing state, empties the queue and sets the file size
// to zero; no clearing pass is needed.
module http_byte_range_parser import hbr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  hbr_in_t                 in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output hbr_out_t                out_word_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [OFFSET_WIDTH-1:0] cfg_data_i
);

  logic [OFFSET_WIDTH-1:0] file_size_q;
  logic                    req_valid, req_take, room;
  hbr_req_t                req;
  hbr_wr_t                 wr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      file_size_q <= cfg_data_i;
    end
  end

  hbr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .req_take_i  (req_take),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  hbr_range u_range (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .file_size_i (file_size_q),
    .room_i      (room),
    .req_take_o  (req_take),
    .wr_o        (wr)
  );

  hbr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
